### rtl/samt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// samt_pkg
// Shared types, register indexes, codes and the CRC-6 helper for the SSI
// angle multiturn tracker.
// ----------------------------------------------------------------------------
package samt_pkg;

  localparam int ANGLE_BITS      = 14;
  localparam int STATUS_BITS     = 4;
  localparam int CRC_BITS        = 6;
  localparam int PAYLOAD_BITS    = ANGLE_BITS + STATUS_BITS;
  localparam int FRAME_BITS      = PAYLOAD_BITS + CRC_BITS;
  localparam int CNT_BITS        = 32;
  localparam int STAMP_BITS      = 64;
  localparam int CFG_DATA_BITS   = 32;
  localparam int CFG_INDEX_BITS  = 2;
  localparam int COUNT_BITS_DEF  = 48;

  localparam logic [ANGLE_BITS-1:0]  MAX_STEP_RST  = 14'd1024;
  localparam logic [STATUS_BITS-1:0] BAD_MASK_RST  = 4'd11;
  localparam logic [31:0]            TIMEOUT_RST   = 32'd10000;

  localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_STEP = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BAD_MASK = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TIMEOUT  = 2'd2;

  typedef enum logic [1:0] {
    FN_FRAME = 2'd0,
    FN_RAW   = 2'd1,
    FN_ZERO  = 2'd2,
    FN_QUERY = 2'd3
  } samt_func_t;

  typedef enum logic [2:0] {
    ERR_NONE   = 3'd0,
    ERR_COMM   = 3'd1,
    ERR_FIELD  = 3'd2,
    ERR_JUMP   = 3'd3,
    ERR_NOINIT = 3'd4
  } samt_err_t;

  typedef struct packed {
    logic [ANGLE_BITS-1:0]  max_step;
    logic [STATUS_BITS-1:0] bad_mask;
    logic [31:0]            timeout;
  } samt_cfg_t;

  typedef struct packed {
    logic [ANGLE_BITS-1:0]  angle;
    logic [STATUS_BITS-1:0] status;
    logic                   link_good;
  } samt_sample_t;

  typedef struct packed {
    logic      ok;
    samt_err_t err;
    logic      fresh;
  } samt_res_t;

  // CRC of a single set payload bit (poly 0x03, init zero, MSB first)
  function automatic logic [CRC_BITS-1:0] crc6_col(input int unsigned pos);
    logic [CRC_BITS-1:0] c;
    case (pos)
      0:       c = 6'h03;
      1:       c = 6'h06;
      2:       c = 6'h0C;
      3:       c = 6'h18;
      4:       c = 6'h30;
      5:       c = 6'h23;
      6:       c = 6'h05;
      7:       c = 6'h0A;
      8:       c = 6'h14;
      9:       c = 6'h28;
      10:      c = 6'h13;
      11:      c = 6'h26;
      12:      c = 6'h0F;
      13:      c = 6'h1E;
      14:      c = 6'h3C;
      15:      c = 6'h3B;
      16:      c = 6'h35;
      17:      c = 6'h29;
      default: c = '0;
    endcase
    return c;
  endfunction

  // CRC is linear with a zero seed: XOR the columns of the set bits
  function automatic logic [CRC_BITS-1:0] crc6(input logic [PAYLOAD_BITS-1:0] data);
    logic [CRC_BITS-1:0] acc;
    acc = '0;
    for (int unsigned i = 0; i < PAYLOAD_BITS; i++) begin
      if (data[i]) begin
        acc = acc ^ crc6_col(i);
      end
    end
    return acc;
  endfunction

  function automatic logic [CNT_BITS-1:0] sat_inc(input logic [CNT_BITS-1:0] v);
    return (v != '1) ? v + CNT_BITS'(1) : v;
  endfunction

endpackage

### rtl/samt_frame_dec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// samt_frame_dec
// Picks angle and status from an SSI frame or from the raw inputs and folds
// the CRC and range checks into one link-good flag.
// ----------------------------------------------------------------------------
module samt_frame_dec (
  input  samt_pkg::samt_func_t                func,
  input  logic [samt_pkg::FRAME_BITS-1:0]     frame,
  input  logic [15:0]                         angle_in,
  input  logic [7:0]                          status_in,
  input  logic                                link_ok,
  output samt_pkg::samt_sample_t              smp
);

  logic [samt_pkg::PAYLOAD_BITS-1:0] payload;
  logic                              crc_ok;

  assign payload = frame[samt_pkg::FRAME_BITS-1:samt_pkg::CRC_BITS];
  assign crc_ok  = samt_pkg::crc6(payload) == frame[samt_pkg::CRC_BITS-1:0];

  always_comb begin
    unique case (func)
      samt_pkg::FN_FRAME: begin
        smp.angle     = payload[samt_pkg::PAYLOAD_BITS-1:samt_pkg::STATUS_BITS];
        smp.status    = payload[samt_pkg::STATUS_BITS-1:0];
        smp.link_good = link_ok && crc_ok;
      end
      samt_pkg::FN_RAW: begin
        smp.angle     = angle_in[samt_pkg::ANGLE_BITS-1:0];
        smp.status    = status_in[samt_pkg::STATUS_BITS-1:0];
        smp.link_good = link_ok && (angle_in[15:samt_pkg::ANGLE_BITS] == '0)
                        && (status_in[7:samt_pkg::STATUS_BITS] == '0);
      end
      default: begin
        smp.angle     = angle_in[samt_pkg::ANGLE_BITS-1:0];
        smp.status    = status_in[samt_pkg::STATUS_BITS-1:0];
        smp.link_good = 1'b0;
      end
    endcase
  end

endmodule

### rtl/samt_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// samt_core
// Tracker state: sample checks, multiturn unwrap, relative zero, error
// counters and freshness. State and result registers update together per item.
// ----------------------------------------------------------------------------
module samt_core #(
  parameter int COUNT_BITS = samt_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                adv,
  input  samt_pkg::samt_func_t                func,
  input  logic [samt_pkg::STAMP_BITS-1:0]     stamp,
  input  samt_pkg::samt_sample_t              smp,
  input  samt_pkg::samt_cfg_t                 cfg,
  output samt_pkg::samt_res_t                 res,
  output logic [samt_pkg::ANGLE_BITS-1:0]     angle_q,
  output logic [samt_pkg::STATUS_BITS-1:0]    status_q,
  output logic [COUNT_BITS-1:0]               count_q,
  output logic [COUNT_BITS:0]                 rel_q,
  output logic [samt_pkg::CNT_BITS-1:0]       link_total_q,
  output logic [samt_pkg::CNT_BITS-1:0]       link_run_q,
  output logic [samt_pkg::CNT_BITS-1:0]       field_total_q,
  output logic [samt_pkg::CNT_BITS-1:0]       jump_total_q
);

  localparam int AB = samt_pkg::ANGLE_BITS;
  localparam int SB = samt_pkg::STAMP_BITS;
  localparam int NB = samt_pkg::CNT_BITS;

  logic [AB-1:0]                  prev_angle_r, prev_angle_nxt;
  logic [samt_pkg::STATUS_BITS-1:0] prev_status_r, prev_status_nxt;
  logic [COUNT_BITS-1:0]          count_r, count_nxt;
  logic [COUNT_BITS-1:0]          zero_r, zero_nxt;
  logic [SB-1:0]                  seen_r, seen_nxt;
  logic [SB-1:0]                  good_r, good_nxt;
  logic [NB-1:0]                  link_total_r, link_total_nxt;
  logic [NB-1:0]                  link_run_r, link_run_nxt;
  logic [NB-1:0]                  field_total_r, field_total_nxt;
  logic [NB-1:0]                  jump_total_r, jump_total_nxt;
  logic                           started_r, started_nxt;
  samt_pkg::samt_res_t            res_r, res_nxt;

  logic [SB-1:0]                  age;
  logic                           fresh_old;
  logic                           stamp_bad;
  logic signed [AB-1:0]           delta;
  logic signed [AB+1:0]           delta_x;
  logic signed [AB+1:0]           step_x;
  logic                           too_far;
  logic [COUNT_BITS:0]            sum;
  logic                           ovf;

  assign age       = stamp - good_r;
  assign fresh_old = started_r && (stamp >= good_r) && (age <= SB'(cfg.timeout));
  assign stamp_bad = (seen_r != '0) && (stamp <= seen_r);

  // 14-bit difference wraps straight into -8192..8191
  assign delta   = $signed(smp.angle - prev_angle_r);
  assign delta_x = {{2{delta[AB-1]}}, delta};
  assign step_x  = $signed({2'b00, cfg.max_step});
  assign too_far = (delta_x > step_x) || (delta_x < -step_x);
  assign sum     = {count_r[COUNT_BITS-1], count_r}
                 + {{(COUNT_BITS + 1 - AB){delta[AB-1]}}, delta};
  assign ovf     = sum[COUNT_BITS] != sum[COUNT_BITS-1];

  always_comb begin
    prev_angle_nxt  = prev_angle_r;
    prev_status_nxt = prev_status_r;
    count_nxt       = count_r;
    zero_nxt        = zero_r;
    seen_nxt        = seen_r;
    good_nxt        = good_r;
    link_total_nxt  = link_total_r;
    link_run_nxt    = link_run_r;
    field_total_nxt = field_total_r;
    jump_total_nxt  = jump_total_r;
    started_nxt     = started_r;
    res_nxt         = res_r;
    if (adv) begin
      res_nxt.ok    = 1'b0;
      res_nxt.err   = samt_pkg::ERR_NONE;
      res_nxt.fresh = fresh_old;
      unique case (func) inside
        samt_pkg::FN_FRAME, samt_pkg::FN_RAW: begin
          if (!smp.link_good || stamp_bad) begin
            link_total_nxt = samt_pkg::sat_inc(link_total_r);
            link_run_nxt   = samt_pkg::sat_inc(link_run_r);
            res_nxt.err    = samt_pkg::ERR_COMM;
          end else begin
            seen_nxt        = stamp;
            link_run_nxt    = '0;
            prev_angle_nxt  = smp.angle;
            prev_status_nxt = smp.status;
            if ((smp.status & cfg.bad_mask) != '0) begin
              field_total_nxt = samt_pkg::sat_inc(field_total_r);
              res_nxt.err     = samt_pkg::ERR_FIELD;
            end else if (!started_r) begin
              count_nxt     = {{(COUNT_BITS - AB){1'b0}}, smp.angle};
              zero_nxt      = {{(COUNT_BITS - AB){1'b0}}, smp.angle};
              good_nxt      = stamp;
              started_nxt   = 1'b1;
              res_nxt.ok    = 1'b1;
              res_nxt.fresh = 1'b1;
            end else if (too_far || ovf) begin
              jump_total_nxt = samt_pkg::sat_inc(jump_total_r);
              res_nxt.err    = samt_pkg::ERR_JUMP;
            end else begin
              count_nxt     = sum[COUNT_BITS-1:0];
              good_nxt      = stamp;
              res_nxt.ok    = 1'b1;
              res_nxt.fresh = 1'b1;
            end
          end
        end
        samt_pkg::FN_ZERO: begin
          if (started_r) begin
            zero_nxt   = count_r;
            res_nxt.ok = 1'b1;
          end else begin
            res_nxt.err = samt_pkg::ERR_NOINIT;
          end
        end
        samt_pkg::FN_QUERY: begin
          if (started_r) begin
            res_nxt.ok = fresh_old;
          end else begin
            res_nxt.err = samt_pkg::ERR_NOINIT;
          end
        end
        default: begin
          res_nxt = res_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_angle_r  <= '0;
      prev_status_r <= '0;
      count_r       <= '0;
      zero_r        <= '0;
      seen_r        <= '0;
      good_r        <= '0;
      link_total_r  <= '0;
      link_run_r    <= '0;
      field_total_r <= '0;
      jump_total_r  <= '0;
      started_r     <= 1'b0;
      res_r         <= '0;
    end else begin
      prev_angle_r  <= prev_angle_nxt;
      prev_status_r <= prev_status_nxt;
      count_r       <= count_nxt;
      zero_r        <= zero_nxt;
      seen_r        <= seen_nxt;
      good_r        <= good_nxt;
      link_total_r  <= link_total_nxt;
      link_run_r    <= link_run_nxt;
      field_total_r <= field_total_nxt;
      jump_total_r  <= jump_total_nxt;
      started_r     <= started_nxt;
      res_r         <= res_nxt;
    end
  end

  assign res           = res_r;
  assign angle_q       = prev_angle_r;
  assign status_q      = prev_status_r;
  assign count_q       = count_r;
  assign rel_q         = {count_r[COUNT_BITS-1], count_r} - {zero_r[COUNT_BITS-1], zero_r};
  assign link_total_q  = link_total_r;
  assign link_run_q    = link_run_r;
  assign field_total_q = field_total_r;
  assign jump_total_q  = jump_total_r;

  a_run_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    link_run_r <= link_total_r)
    else $error("consecutive link errors exceed total");

  a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
    !started_r |-> (count_r == '0) && (zero_r == '0) && (good_r == '0))
    else $error("count moved before first valid sample");

  a_good_time: assert property (@(posedge clk) disable iff (!rst_n)
    adv && res_nxt.ok && (func == samt_pkg::FN_FRAME || func == samt_pkg::FN_RAW)
    |=> good_r == $past(stamp))
    else $error("valid sample did not record its time");

  a_noinit: assert property (@(posedge clk) disable iff (!rst_n)
    adv && (res_nxt.err == samt_pkg::ERR_NOINIT) |-> !started_r)
    else $error("not-initialized answer after start");

endmodule

### rtl/ssi_angle_multiturn_tracker_unit.sv
`timescale 1ns / 1ps
// An accepted item waits in the input register; when the result slot is free
// or drained, its result and out_valid are registered together.
// Throughput: one item per cycle while out_stall is low; tracker state
// updates from the input register, so consecutive items chain with no gaps.
// Reset (rst_n low, synchronous): clears all tracker state and error
// counters, empties both registers, loads default configuration.
// ----------------------------------------------------------------------------
// ssi_angle_multiturn_tracker_unit
// Top level: input register, result handshake, configuration registers.
// ----------------------------------------------------------------------------
module ssi_angle_multiturn_tracker_unit #(
  parameter int COUNT_BITS = samt_pkg::COUNT_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     cfg_we,
  input  logic [samt_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
  input  logic [samt_pkg::CFG_DATA_BITS-1:0]       cfg_data,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic [1:0]                               in_func,
  input  logic [samt_pkg::FRAME_BITS-1:0]          in_frame,
  input  logic [15:0]                              in_angle_in,
  input  logic [7:0]                               in_status_in,
  input  logic [samt_pkg::STAMP_BITS-1:0]          in_stamp,
  input  logic                                     in_link_ok,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic                                     out_ok,
  output logic [2:0]                               out_error_kind,
  output logic [samt_pkg::ANGLE_BITS-1:0]          out_angle_out,
  output logic [samt_pkg::STATUS_BITS-1:0]         out_status_out,
  output logic signed [COUNT_BITS-1:0]             out_turn_count,
  output logic signed [COUNT_BITS:0]               out_rel_count,
  output logic [samt_pkg::CNT_BITS-1:0]            out_link_errors,
  output logic [samt_pkg::CNT_BITS-1:0]            out_link_errors_run,
  output logic [samt_pkg::CNT_BITS-1:0]            out_field_errors,
  output logic [samt_pkg::CNT_BITS-1:0]            out_jump_errors,
  output logic                                     out_fresh
);

  samt_pkg::samt_cfg_t              cfg_r, cfg_nxt;
  logic                             s_valid_r, s_valid_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [1:0]                       s_func_r;
  logic [samt_pkg::FRAME_BITS-1:0]  s_frame_r;
  logic [15:0]                      s_angle_r;
  logic [7:0]                       s_status_r;
  logic [samt_pkg::STAMP_BITS-1:0]  s_stamp_r;
  logic                             s_link_r;
  logic                             in_take;
  logic                             adv;
  samt_pkg::samt_func_t             s_func;
  samt_pkg::samt_sample_t           smp;
  samt_pkg::samt_res_t              res;
  logic [COUNT_BITS-1:0]            count_q;
  logic [COUNT_BITS:0]              rel_q;

  // advance the held item when the result slot is free or being drained
  assign adv      = s_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s_valid_r && !adv;
  assign in_take  = in_valid && !in_stall;
  assign s_func   = samt_pkg::samt_func_t'(s_func_r);

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        samt_pkg::REG_MAX_STEP: cfg_nxt.max_step = cfg_data[samt_pkg::ANGLE_BITS-1:0];
        samt_pkg::REG_BAD_MASK: cfg_nxt.bad_mask = cfg_data[samt_pkg::STATUS_BITS-1:0];
        samt_pkg::REG_TIMEOUT:  cfg_nxt.timeout  = cfg_data[31:0];
        default:                cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    s_valid_nxt = in_take || (s_valid_r && !adv);
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_step <= samt_pkg::MAX_STEP_RST;
      cfg_r.bad_mask <= samt_pkg::BAD_MASK_RST;
      cfg_r.timeout  <= samt_pkg::TIMEOUT_RST;
      s_valid_r      <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      cfg_r          <= cfg_nxt;
      s_valid_r      <= s_valid_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s_func_r   <= in_func;
      s_frame_r  <= in_frame;
      s_angle_r  <= in_angle_in;
      s_status_r <= in_status_in;
      s_stamp_r  <= in_stamp;
      s_link_r   <= in_link_ok;
    end
  end

  samt_frame_dec u_dec (
    .func      (s_func),
    .frame     (s_frame_r),
    .angle_in  (s_angle_r),
    .status_in (s_status_r),
    .link_ok   (s_link_r),
    .smp       (smp)
  );

  samt_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .adv           (adv),
    .func          (s_func),
    .stamp         (s_stamp_r),
    .smp           (smp),
    .cfg           (cfg_r),
    .res           (res),
    .angle_q       (out_angle_out),
    .status_q      (out_status_out),
    .count_q       (count_q),
    .rel_q         (rel_q),
    .link_total_q  (out_link_errors),
    .link_run_q    (out_link_errors_run),
    .field_total_q (out_field_errors),
    .jump_total_q  (out_jump_errors)
  );

  assign out_valid      = out_valid_r;
  assign out_ok         = res.ok;
  assign out_error_kind = res.err;
  assign out_fresh      = res.fresh;
  assign out_turn_count = $signed(count_q);
  assign out_rel_count  = $signed(rel_q);

endmodule

### verif/tb_ssi_angle_multiturn_tracker_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ssi_angle_multiturn_tracker_unit
// Self-checking bench for the SSI angle tracker. Directed items cover the
// uninitialized state, the zero-stamp rule, stamp ordering, step limits,
// faults, the relative zero and freshness. Randomized sample streams then
// run under changing configuration and flow control. A tracker model in the
// bench predicts every result, and each field is compared on arrival.
// ----------------------------------------------------------------------------
module tb_ssi_angle_multiturn_tracker_unit;
  import samt_pkg::*;

  localparam int          CLK_PERIOD  = 12;
  localparam int          RUN_LIMIT   = 400000;
  localparam int          SEG_ITEMS   = 87;
  localparam int          HOLD_CYCLES = 60;
  localparam int          TURN_BITS   = COUNT_BITS_DEF;
  localparam logic [63:0] STAMP_TOP   = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic                 ok;
    samt_err_t            err;
    logic [13:0]          angle;
    logic [3:0]           status;
    logic [TURN_BITS-1:0] turns;
    logic [TURN_BITS:0]   rel;
    logic [31:0]          link_total;
    logic [31:0]          link_run;
    logic [31:0]          field_total;
    logic [31:0]          jump_total;
    logic                 fresh;
  } track_report_t;

  logic                        clk;
  logic                        rst_n;
  logic                        cfg_we;
  logic [CFG_INDEX_BITS-1:0]   cfg_index;
  logic [CFG_DATA_BITS-1:0]    cfg_data;
  logic                        in_valid;
  logic                        in_stall;
  logic [1:0]                  in_func;
  logic [FRAME_BITS-1:0]       in_frame;
  logic [15:0]                 in_angle_in;
  logic [7:0]                  in_status_in;
  logic [STAMP_BITS-1:0]       in_stamp;
  logic                        in_link_ok;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic                        out_ok;
  logic [2:0]                  out_error_kind;
  logic [ANGLE_BITS-1:0]       out_angle_out;
  logic [STATUS_BITS-1:0]      out_status_out;
  logic signed [TURN_BITS-1:0] out_turn_count;
  logic signed [TURN_BITS:0]   out_rel_count;
  logic [CNT_BITS-1:0]         out_link_errors;
  logic [CNT_BITS-1:0]         out_link_errors_run;
  logic [CNT_BITS-1:0]         out_field_errors;
  logic [CNT_BITS-1:0]         out_jump_errors;
  logic                        out_fresh;

  // tracker model state and its copy of the registers
  logic [13:0]                 trk_prev_angle;
  logic [3:0]                  trk_prev_status;
  logic signed [TURN_BITS-1:0] trk_count;
  logic signed [TURN_BITS-1:0] trk_zero;
  logic [63:0]                 trk_last_seen;
  logic [63:0]                 trk_last_good;
  logic [31:0]                 trk_link_total;
  logic [31:0]                 trk_link_run;
  logic [31:0]                 trk_field_total;
  logic [31:0]                 trk_jump_total;
  logic                        trk_started;
  logic [13:0]                 trk_max_step;
  logic [3:0]                  trk_bad_mask;
  logic [31:0]                 trk_timeout;

  track_report_t pending_reports[$];
  int            mismatches;

  // stimulus side: what the generator believes about the sensor
  logic [13:0] stim_angle;
  logic [63:0] stim_time;
  logic [13:0] cur_step;
  logic [3:0]  cur_mask;
  logic [31:0] cur_timeout;
  int          config_round;
  int          tx_idle_pct;
  int          rx_idle_pct;
  bit          stall_hold_req;
  int          stall_hold_left;
  int          cycle_count;

  ssi_angle_multiturn_tracker_unit dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_func             (in_func),
    .in_frame            (in_frame),
    .in_angle_in         (in_angle_in),
    .in_status_in        (in_status_in),
    .in_stamp            (in_stamp),
    .in_link_ok          (in_link_ok),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_ok              (out_ok),
    .out_error_kind      (out_error_kind),
    .out_angle_out       (out_angle_out),
    .out_status_out      (out_status_out),
    .out_turn_count      (out_turn_count),
    .out_rel_count       (out_rel_count),
    .out_link_errors     (out_link_errors),
    .out_link_errors_run (out_link_errors_run),
    .out_field_errors    (out_field_errors),
    .out_jump_errors     (out_jump_errors),
    .out_fresh           (out_fresh)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // ---------------------------------------------------------------- model

  // bit-serial CRC-6, poly 0x03, zero seed, MSB first
  function automatic logic [5:0] frame_crc(input logic [17:0] payload);
    logic [5:0] crc;
    logic       fb;
    crc = '0;
    for (int i = 17; i >= 0; i--) begin
      fb  = crc[5] ^ payload[i];
      crc = {crc[4:0], 1'b0};
      if (fb) begin
        crc = crc ^ 6'h03;
      end
    end
    return crc;
  endfunction

  function automatic logic [31:0] bump_sat(input logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

  function automatic logic fresh_at(input logic [63:0] now);
    if (!trk_started || now < trk_last_good) begin
      return 1'b0;
    end
    return (now - trk_last_good) <= {32'h0, trk_timeout};
  endfunction

  function automatic samt_err_t take_sample(input logic [15:0] angle, input logic [7:0] status,
                                            input logic [63:0] stamp, input logic link);
    int                     now_a;
    int                     old_a;
    int                     delta;
    int                     lim;
    logic [TURN_BITS:0]     count_sum;
    if (trk_last_seen != 64'd0 && stamp <= trk_last_seen) begin
      link = 1'b0;
    end
    if (!link || angle[15:14] != 2'b00 || status[7:4] != 4'h0) begin
      trk_link_total = bump_sat(trk_link_total);
      trk_link_run   = bump_sat(trk_link_run);
      return ERR_COMM;
    end
    trk_last_seen = stamp;
    trk_link_run  = '0;
    if ((status[3:0] & trk_bad_mask) != 4'h0) begin
      trk_prev_angle  = angle[13:0];
      trk_prev_status = status[3:0];
      trk_field_total = bump_sat(trk_field_total);
      return ERR_FIELD;
    end
    if (!trk_started) begin
      trk_prev_angle  = angle[13:0];
      trk_prev_status = status[3:0];
      trk_count       = {{(TURN_BITS - 14){1'b0}}, angle[13:0]};
      trk_zero        = trk_count;
      trk_last_good   = stamp;
      trk_started     = 1'b1;
      return ERR_NONE;
    end
    now_a = int'(angle[13:0]);
    old_a = int'(trk_prev_angle);
    delta = now_a - old_a;
    // take the short way around the circle
    if (delta >= 8192) begin
      delta = delta - 16384;
    end else if (delta < -8192) begin
      delta = delta + 16384;
    end
    trk_prev_angle  = angle[13:0];
    trk_prev_status = status[3:0];
    lim       = int'(trk_max_step);
    count_sum = {trk_count[TURN_BITS-1], trk_count} + (TURN_BITS + 1)'(delta);
    if (delta > lim || delta < -lim || count_sum[TURN_BITS] != count_sum[TURN_BITS-1]) begin
      trk_jump_total = bump_sat(trk_jump_total);
      return ERR_JUMP;
    end
    trk_count     = count_sum[TURN_BITS-1:0];
    trk_last_good = stamp;
    return ERR_NONE;
  endfunction

  function automatic track_report_t track_item(input logic [1:0] fn, input logic [23:0] frame,
                                               input logic [15:0] ang, input logic [7:0] st,
                                               input logic [63:0] stamp, input logic link);
    track_report_t r;
    logic [17:0]   payload;
    r       = '0;
    r.err   = ERR_NONE;
    payload = frame[23:6];
    case (samt_func_t'(fn))
      FN_FRAME: begin
        r.err = take_sample({2'b00, payload[17:4]}, {4'h0, payload[3:0]}, stamp,
                            link && (frame_crc(payload) == frame[5:0]));
        r.ok  = (r.err == ERR_NONE);
      end
      FN_RAW: begin
        r.err = take_sample(ang, st, stamp, link);
        r.ok  = (r.err == ERR_NONE);
      end
      FN_ZERO: begin
        if (trk_started) begin
          trk_zero = trk_count;
          r.ok     = 1'b1;
        end else begin
          r.err = ERR_NOINIT;
        end
      end
      FN_QUERY: begin
        if (trk_started) begin
          r.ok = fresh_at(stamp);
        end else begin
          r.err = ERR_NOINIT;
        end
      end
    endcase
    r.angle       = trk_prev_angle;
    r.status      = trk_prev_status;
    r.turns       = trk_count;
    r.rel         = {trk_count[TURN_BITS-1], trk_count} - {trk_zero[TURN_BITS-1], trk_zero};
    r.link_total  = trk_link_total;
    r.link_run    = trk_link_run;
    r.field_total = trk_field_total;
    r.jump_total  = trk_jump_total;
    r.fresh       = fresh_at(stamp);
    return r;
  endfunction

  task automatic tracker_reset();
    trk_prev_angle  = '0;
    trk_prev_status = '0;
    trk_count       = '0;
    trk_zero        = '0;
    trk_last_seen   = '0;
    trk_last_good   = '0;
    trk_link_total  = '0;
    trk_link_run    = '0;
    trk_field_total = '0;
    trk_jump_total  = '0;
    trk_started     = 1'b0;
    trk_max_step    = MAX_STEP_RST;
    trk_bad_mask    = BAD_MASK_RST;
    trk_timeout     = TIMEOUT_RST;
    cur_step        = MAX_STEP_RST;
    cur_mask        = BAD_MASK_RST;
    cur_timeout     = TIMEOUT_RST;
  endtask

  // ---------------------------------------------------------------- checking

  task automatic flag_mismatch(input string msg);
    mismatches++;
    $display("%0t ns: %s", $time, msg);
  endtask

  task automatic check_field(input string what, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      flag_mismatch($sformatf("%s mismatch: expected %0h, actual %0h", what, want, got));
    end
  endtask

  always @(posedge clk) begin : result_monitor
    track_report_t want;
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MAX_STEP: trk_max_step = cfg_data[13:0];
          REG_BAD_MASK: trk_bad_mask = cfg_data[3:0];
          REG_TIMEOUT:  trk_timeout  = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        pending_reports.push_back(track_item(in_func, in_frame, in_angle_in, in_status_in,
                                             in_stamp, in_link_ok));
      end
      if (out_valid && !out_stall) begin
        if (pending_reports.size() == 0) begin
          flag_mismatch("result arrived with no item pending");
        end else begin
          want = pending_reports.pop_front();
          check_field("ok", 64'(want.ok), 64'(out_ok));
          check_field("error_kind", 64'(want.err), 64'(out_error_kind));
          check_field("angle_out", 64'(want.angle), 64'(out_angle_out));
          check_field("status_out", 64'(want.status), 64'(out_status_out));
          check_field("turn_count", 64'(want.turns), 64'(out_turn_count[TURN_BITS-1:0]));
          check_field("rel_count", 64'(want.rel), 64'(out_rel_count[TURN_BITS:0]));
          check_field("link_errors", 64'(want.link_total), 64'(out_link_errors));
          check_field("link_errors_run", 64'(want.link_run), 64'(out_link_errors_run));
          check_field("field_errors", 64'(want.field_total), 64'(out_field_errors));
          check_field("jump_errors", 64'(want.jump_total), 64'(out_jump_errors));
          check_field("fresh", 64'(want.fresh), 64'(out_fresh));
        end
      end
    end
  end

  // receiver: random stall, or a counted hold-off when asked
  always @(negedge clk) begin
    if (stall_hold_left > 0) begin
      out_stall = 1'b1;
      stall_hold_left--;
    end else if (stall_hold_req) begin
      stall_hold_req  = 1'b0;
      stall_hold_left = HOLD_CYCLES - 1;
      out_stall       = 1'b1;
    end else begin
      out_stall = ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------- driving

  task automatic send_item(input samt_func_t fn, input logic [23:0] frame,
                           input logic [15:0] ang, input logic [7:0] st,
                           input logic [63:0] stamp, input logic link);
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_func      = fn;
    in_frame     = frame;
    in_angle_in  = ang;
    in_status_in = st;
    in_stamp     = stamp;
    in_link_ok   = link;
    in_valid     = 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic logic [23:0] pack_frame(input logic [13:0] a, input logic [3:0] s,
                                             input logic corrupt);
    logic [5:0] crc;
    crc = frame_crc({a, s});
    if (corrupt) begin
      crc = crc ^ 6'($urandom_range(1, 63));
    end
    return {a, s, crc};
  endfunction

  task automatic send_frame(input logic [13:0] a, input logic [3:0] s, input logic [63:0] stamp,
                            input logic link, input logic corrupt);
    send_item(FN_FRAME, pack_frame(a, s, corrupt), 16'($urandom), 8'($urandom), stamp, link);
  endtask

  task automatic send_raw(input logic [15:0] a, input logic [7:0] s, input logic [63:0] stamp,
                          input logic link);
    send_item(FN_RAW, 24'($urandom), a, s, stamp, link);
  endtask

  task automatic send_op(input samt_func_t fn, input logic [63:0] stamp);
    send_item(fn, 24'($urandom), 16'($urandom), 8'($urandom), stamp, 1'($urandom));
  endtask

  // hold off until every pending result is back, then let the pipe settle
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic apply_config(input logic [31:0] step, input logic [31:0] mask,
                              input logic [31:0] tmo);
    write_reg(REG_MAX_STEP, step);
    write_reg(REG_BAD_MASK, mask);
    write_reg(REG_TIMEOUT, tmo);
    cur_step    = step[13:0];
    cur_mask    = mask[3:0];
    cur_timeout = tmo;
  endtask

  task automatic apply_next_config();
    case (config_round)
      0: apply_config(32'd0, 32'd0, 32'd0);
      1: apply_config(32'd8192, 32'd15, 32'hFFFF_FFFF);
      default: begin
        apply_config(($urandom_range(0, 3) == 0) ? 32'd8192 : $urandom_range(0, 2048),
                     $urandom_range(0, 15),
                     ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 20000));
      end
    endcase
    config_round++;
  endtask

  // mostly plausible sensor samples near the last angle, some ops and noise
  task automatic send_random_item();
    int          pick;
    int          step_i;
    int          d;
    logic [13:0] a;
    logic [3:0]  s;
    logic [63:0] stamp;
    logic [63:0] q;
    bit          moves;
    pick   = $urandom_range(0, 99);
    step_i = int'(cur_step);
    stamp  = stim_time + 64'($urandom_range(1, 3000));
    if ($urandom_range(0, 99) == 0) begin
      stamp = stim_time + 64'd1 + (64'($urandom) << $urandom_range(0, 24));
    end
    d = $urandom_range(0, 2 * step_i);
    d = d - step_i;
    if ($urandom_range(0, 7) == 0) begin
      d = ($urandom_range(0, 1) == 1) ? step_i : -step_i;
    end
    a     = 14'(int'(stim_angle) + d);
    s     = 4'($urandom) & ~cur_mask;
    moves = 1'b1;
    if (pick < 45) begin
      send_frame(a, s, stamp, 1'b1, 1'b0);
      stim_angle = a;
    end else if (pick < 62) begin
      send_raw({2'b00, a}, {4'h0, s}, stamp, 1'b1);
      stim_angle = a;
    end else if (pick < 70) begin
      case ($urandom_range(0, 3))
        0: q = stim_time + 64'($urandom_range(0, 20000));
        1: q = stim_time + 64'(cur_timeout) + 64'($urandom_range(0, 1));
        2: q = {$urandom, $urandom};
        default: q = stim_time - 64'($urandom_range(0, 3000));
      endcase
      send_op(FN_QUERY, q);
      moves = 1'b0;
    end else if (pick < 75) begin
      send_op(FN_ZERO, {$urandom, $urandom});
      moves = 1'b0;
    end else begin
      case ($urandom_range(0, 7))
        0: send_frame(a, s, stamp, 1'b1, 1'b1);
        1: begin
          if ($urandom_range(0, 1) == 1) begin
            send_frame(a, s, stamp, 1'b0, 1'b0);
          end else begin
            send_raw({2'b00, a}, {4'h0, s}, stamp, 1'b0);
          end
        end
        2: begin
          send_raw({2'b00, a}, {4'h0, s}, stim_time - 64'($urandom_range(0, 2)), 1'b1);
          moves = 1'b0;
        end
        3: send_raw({2'($urandom_range(1, 3)), a}, {4'h0, s}, stamp, 1'b1);
        4: send_raw({2'b00, a}, {4'($urandom_range(1, 15)), s}, stamp, 1'b1);
        5: begin
          s = 4'($urandom_range(1, 15));
          if ($urandom_range(0, 1) == 1) begin
            send_frame(a, s, stamp, 1'b1, 1'b0);
          end else begin
            send_raw({2'b00, a}, {4'h0, s}, stamp, 1'b1);
          end
          stim_angle = a;
        end
        6: begin
          a = 14'($urandom);
          send_raw({2'b00, a}, {4'h0, s}, stamp, 1'b1);
          stim_angle = a;
        end
        default: begin
          send_item(samt_func_t'($urandom_range(0, 3)), 24'($urandom), 16'($urandom),
                    8'($urandom), stamp, 1'($urandom));
        end
      endcase
    end
    if (moves) begin
      stim_time = stamp;
    end
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_uninitialized();
    send_op(FN_ZERO, 64'd0);
    send_op(FN_QUERY, 64'd0);
    send_frame(14'd100, 4'h0, 64'd0, 1'b1, 1'b1);
    send_raw(16'h8000, 8'h00, 64'd0, 1'b1);
    send_raw(16'h4000, 8'h00, 64'd0, 1'b1);
    send_raw(16'h0010, 8'hF0, 64'd0, 1'b1);
    send_raw(16'h0010, 8'h00, 64'd0, 1'b0);
    // field fault at stamp zero leaves no stamp seen
    send_raw(16'h3FFF, 8'h08, 64'd0, 1'b1);
  endtask

  task automatic test_stamp_order();
    send_frame(14'h3FFF, 4'h4, 64'd0, 1'b1, 1'b0);
    // stamp zero still counts as none seen, so this one passes and wraps up
    send_raw(16'h0000, 8'h00, 64'd0, 1'b1);
    send_raw(16'h3FFF, 8'h04, 64'd10, 1'b1);
    send_raw(16'h0000, 8'h00, 64'd10, 1'b1);
    send_raw(16'h0000, 8'h00, 64'd7, 1'b1);
  endtask

  task automatic test_step_limits();
    send_raw(16'd1023, 8'h00, 64'd20, 1'b1);
    send_raw(16'h3FFF, 8'h00, 64'd30, 1'b1);
    send_raw(16'd1024, 8'h00, 64'd40, 1'b1);
    // half a turn away wraps to the negative extreme
    send_raw(16'd9216, 8'h00, 64'd50, 1'b1);
    send_frame(14'd9216, 4'hF, 64'd60, 1'b1, 1'b0);
  endtask

  task automatic test_zero_and_freshness();
    send_op(FN_ZERO, 64'd61);
    send_op(FN_QUERY, 64'd30 + 64'd10000);
    send_op(FN_QUERY, 64'd30 + 64'd10001);
    send_op(FN_QUERY, 64'd29);
    stim_angle = 14'd9216;
    stim_time  = 64'd60;
  endtask

  task automatic test_random_traffic(input int tx_pct, input int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int seg = 0; seg < 3; seg++) begin
      wait_drained();
      apply_next_config();
      repeat (SEG_ITEMS) send_random_item();
    end
  endtask

  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    wait_drained();
    stall_hold_req = 1'b1;
    repeat (30) send_random_item();
    wait_drained();
    repeat (10) send_random_item();
  endtask

  task automatic test_stamp_ceiling();
    wait_drained();
    apply_config(32'd8192, 32'd0, 32'd100);
    send_raw({2'b00, stim_angle}, 8'h00, STAMP_TOP - 64'd15, 1'b1);
    send_op(FN_QUERY, STAMP_TOP);
    send_raw({2'b00, stim_angle}, 8'h00, STAMP_TOP, 1'b1);
    send_raw({2'b00, stim_angle}, 8'h00, STAMP_TOP, 1'b1);
    send_op(FN_QUERY, 64'd0);
  endtask

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    in_valid        = 1'b0;
    in_func         = FN_FRAME;
    in_frame        = '0;
    in_angle_in     = '0;
    in_status_in    = '0;
    in_stamp        = '0;
    in_link_ok      = 1'b0;
    mismatches      = 0;
    config_round    = 0;
    tx_idle_pct     = 25;
    rx_idle_pct     = 25;
    stall_hold_req  = 1'b0;
    stall_hold_left = 0;
    stim_angle      = '0;
    stim_time       = '0;
    tracker_reset();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_uninitialized();
    test_stamp_order();
    test_step_limits();
    test_zero_and_freshness();
    test_random_traffic(25, 88);
    test_random_traffic(88, 25);
    test_random_traffic(0, 0);
    test_backpressure();
    test_stamp_ceiling();
    wait_drained();

    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### ssi_angle_multiturn_tracker_unit.f
rtl/samt_pkg.sv
rtl/samt_frame_dec.sv
rtl/samt_core.sv
rtl/ssi_angle_multiturn_tracker_unit.sv
verif/tb_ssi_angle_multiturn_tracker_unit.sv
